### sv/pcicfg_pkg.sv
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared types, constants and reset tables of the configuration header.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

   localparam int HEADER_BYTES_DEF = 256;

   // byte index of one access byte: offset plus lane, up to 255 + 7
   localparam int IDX_W = 9;

   // access sizes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_HALF  = 2'd1;
   localparam logic [1:0] SIZE_WORD  = 2'd2;
   localparam logic [1:0] SIZE_QUAD  = 2'd3;

   // access types
   localparam logic TYPE_READ  = 1'b0;
   localparam logic TYPE_WRITE = 1'b1;

   // frame buffer base register
   localparam logic [7:0]  BASE_OFFSET = 8'h10;
   localparam logic [31:0] BASE_ONES   = 32'hffff_ffff;
   localparam logic [31:0] BASE_ZERO   = 32'h0000_0000;
   localparam logic [31:0] BASE_KEEP   = 32'hffff_fffe;

   // bytes that hold writable bits
   localparam logic [IDX_W-1:0] REG_CMD_LO   = 9'h004;
   localparam logic [IDX_W-1:0] REG_LINE_SZ  = 9'h00c;
   localparam logic [IDX_W-1:0] REG_LAT_TMR  = 9'h00d;
   localparam logic [IDX_W-1:0] REG_BAR0_HI  = 9'h013;
   localparam logic [IDX_W-1:0] REG_INT_LINE = 9'h03c;

   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } byte_op_type;

   function automatic logic [7:0] default_byte(input logic [IDX_W-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         9'h000:  val = 8'h33;
         9'h001:  val = 8'h53;
         9'h002:  val = 8'h11;
         9'h003:  val = 8'h88;
         9'h006:  val = 8'h1f;
         9'h007:  val = 8'h01;
         9'h008:  val = 8'h02;
         9'h00b:  val = 8'h03;
         9'h013:  val = 8'hf8;
         9'h03c:  val = 8'hff;
         9'h03d:  val = 8'h01;
         9'h03e:  val = 8'h14;
         9'h03f:  val = 8'h28;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] write_mask(input logic [IDX_W-1:0] idx);
      logic [7:0] val;
      unique case (idx)
         REG_CMD_LO:   val = 8'hff;
         REG_LINE_SZ:  val = 8'hff;
         REG_LAT_TMR:  val = 8'hff;
         REG_BAR0_HI:  val = 8'hfc;
         REG_INT_LINE: val = 8'hff;
         default:      val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### sv/pcicfg_store.sv
// ----------------------------------------------------------------------------
// pcicfg_store
// Byte store of the header: fixed bytes from the reset table, writable bytes
// in registers, one masked byte write and one byte read per cycle.
// ----------------------------------------------------------------------------
module pcicfg_store (
   input  logic                      clock,
   input  logic                      reset,
   input  pcicfg_pkg::byte_op_type   op,
   output logic [7:0]                rd_byte
);

   logic [7:0] cmd_lo_ff,   cmd_lo_in;
   logic [7:0] line_sz_ff,  line_sz_in;
   logic [7:0] lat_tmr_ff,  lat_tmr_in;
   logic [7:0] bar0_hi_ff,  bar0_hi_in;
   logic [7:0] int_line_ff, int_line_in;
   logic [7:0] mask;
   logic [7:0] merged;

   always_comb begin
      mask   = pcicfg_pkg::write_mask(op.idx);
      merged = (rd_byte & ~mask) | (op.data & mask);
   end

   always_comb begin
      unique case (op.idx)
         pcicfg_pkg::REG_CMD_LO:   rd_byte = cmd_lo_ff;
         pcicfg_pkg::REG_LINE_SZ:  rd_byte = line_sz_ff;
         pcicfg_pkg::REG_LAT_TMR:  rd_byte = lat_tmr_ff;
         pcicfg_pkg::REG_BAR0_HI:  rd_byte = bar0_hi_ff;
         pcicfg_pkg::REG_INT_LINE: rd_byte = int_line_ff;
         default:                  rd_byte = pcicfg_pkg::default_byte(op.idx);
      endcase
   end

   always_comb begin
      cmd_lo_in   = cmd_lo_ff;
      line_sz_in  = line_sz_ff;
      lat_tmr_in  = lat_tmr_ff;
      bar0_hi_in  = bar0_hi_ff;
      int_line_in = int_line_ff;
      if (op.wr) begin
         unique case (op.idx)
            pcicfg_pkg::REG_CMD_LO:   cmd_lo_in   = merged;
            pcicfg_pkg::REG_LINE_SZ:  line_sz_in  = merged;
            pcicfg_pkg::REG_LAT_TMR:  lat_tmr_in  = merged;
            pcicfg_pkg::REG_BAR0_HI:  bar0_hi_in  = merged;
            pcicfg_pkg::REG_INT_LINE: int_line_in = merged;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_lo_ff   <= pcicfg_pkg::default_byte(pcicfg_pkg::REG_CMD_LO);
         line_sz_ff  <= pcicfg_pkg::default_byte(pcicfg_pkg::REG_LINE_SZ);
         lat_tmr_ff  <= pcicfg_pkg::default_byte(pcicfg_pkg::REG_LAT_TMR);
         bar0_hi_ff  <= pcicfg_pkg::default_byte(pcicfg_pkg::REG_BAR0_HI);
         int_line_ff <= pcicfg_pkg::default_byte(pcicfg_pkg::REG_INT_LINE);
      end else begin
         cmd_lo_ff   <= cmd_lo_in;
         line_sz_ff  <= line_sz_in;
         lat_tmr_ff  <= lat_tmr_in;
         bar0_hi_ff  <= bar0_hi_in;
         int_line_ff <= int_line_in;
      end
   end

endmodule

### sv/pci_config_space_masked_core.sv
// ----------------------------------------------------------------------------
// pci_config_space_masked_core
// Type 0 configuration header with per-byte write masks, accessed one byte
// lane per cycle through a shared merge unit, and frame buffer base tracking.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  type, offset, size, write data
//   rsp_      out         rsp_valid / rsp_stall  read data, base moved, base
//
// A transaction's response becomes valid once its byte count (1, 2, 4 or 8)
// of lanes has passed, one byte lane per cycle, through the store's merge
// unit. The next transaction is accepted only after the response is taken,
// and rsp_stall holds the response and so delays the next acceptance.
// req_stall is high from the cycle after acceptance until the cycle after the
// response is taken. Reset is synchronous and restores the header defaults.
// ----------------------------------------------------------------------------
module pci_config_space_masked_core #(
   parameter int HEADER_BYTES = pcicfg_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_byte_offset,
   input  logic [1:0]  req_access_size,
   input  logic [63:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic        rsp_base_moved,
   output logic [31:0] rsp_base_address
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type   state_ff, state_in;
   logic        wr_ff, wr_in;
   logic [7:0]  offset_ff, offset_in;
   logic [2:0]  last_ff, last_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] data_ff, data_in;
   logic [63:0] rd_ff, rd_in;
   logic        move_ff, move_in;
   logic [31:0] base_ff, base_in;

   logic [pcicfg_pkg::IDX_W-1:0] idx;
   logic                         in_range;
   logic                         base_hit;
   logic [7:0]                   rd_byte;
   pcicfg_pkg::byte_op_type      op;

   pcicfg_store u_store (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .rd_byte (rd_byte)
   );

   always_comb begin
      idx      = {1'b0, offset_ff} + {6'b0, step_ff};
      in_range = 32'(idx) < 32'(HEADER_BYTES);
      op.wr    = (state_ff == ST_RUN) && (wr_ff == pcicfg_pkg::TYPE_WRITE) && in_range;
      op.idx   = idx;
      op.data  = data_ff[7:0];
      base_hit = (req_type == pcicfg_pkg::TYPE_WRITE)
              && (req_access_size == pcicfg_pkg::SIZE_WORD)
              && (req_byte_offset == pcicfg_pkg::BASE_OFFSET)
              && (req_write_data[31:0] != pcicfg_pkg::BASE_ONES)
              && (req_write_data[31:0] != pcicfg_pkg::BASE_ZERO);
   end

   always_comb begin
      state_in  = state_ff;
      wr_in     = wr_ff;
      offset_in = offset_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      data_in   = data_ff;
      rd_in     = rd_ff;
      move_in   = move_ff;
      base_in   = base_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               wr_in     = req_type;
               offset_in = req_byte_offset;
               step_in   = 3'd0;
               data_in   = req_write_data;
               rd_in     = 64'd0;
               move_in   = base_hit;
               if (base_hit) begin
                  base_in = req_write_data[31:0];
               end
               unique case (req_access_size)
                  pcicfg_pkg::SIZE_BYTE: last_in = 3'd0;
                  pcicfg_pkg::SIZE_HALF: last_in = 3'd1;
                  pcicfg_pkg::SIZE_WORD: last_in = 3'd3;
                  pcicfg_pkg::SIZE_QUAD: last_in = 3'd7;
                  default:               last_in = 3'd0;
               endcase
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if ((wr_ff == pcicfg_pkg::TYPE_READ) && in_range) begin
               rd_in[8*step_ff +: 8] = rd_byte;
            end
            data_in = {8'd0, data_ff[63:8]};
            step_in = step_ff + 3'd1;
            if (step_ff == last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         move_ff  <= 1'b0;
         base_ff  <= 32'd0;
      end else begin
         state_ff <= state_in;
         move_ff  <= move_in;
         base_ff  <= base_in;
      end
      wr_ff     <= wr_in;
      offset_ff <= offset_in;
      last_ff   <= last_in;
      step_ff   <= step_in;
      data_ff   <= data_in;
      rd_ff     <= rd_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_read_data    = rd_ff;
   assign rsp_base_moved   = move_ff;
   assign rsp_base_address = base_ff & pcicfg_pkg::BASE_KEEP;

endmodule
